FILE: rtl/core/bfha_pkg.sv
// Shared types and constants of the best-fit heap allocator.
package bfha_pkg;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 24;
    localparam int CFG_W  = 32;

    // Internal offsets and sizes carry two spare bits so that sums of a
    // 32-bit size, an offset and a header never wrap.
    localparam int WORD_W = 34;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_word NIL   = 34'h0_FFFF_FFFF;
    localparam t_word HDR   = 34'd4;
    localparam t_word SPLIT = 34'd8;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_END  = 1'b1;

    localparam logic [CFG_W-1:0] HEAP_END_RESET = 32'd16384;

    typedef enum logic [1:0] {
        CTX_ALLOC,
        CTX_FREE,
        CTX_SHRINK,
        CTX_MOVE
    } t_ctx;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_REL,
        S_DONE,
        S_A_INIT,
        S_A_LOOP,
        S_A_SZ,
        S_A_NEXT,
        S_A_AFTER,
        S_A_SPL,
        S_A_SPL2,
        S_A_RET,
        S_F_INIT,
        S_F_CHK,
        S_F_EMPTY,
        S_F_LOOP,
        S_F_ADV,
        S_F_M1,
        S_F_M2,
        S_F_M3,
        S_F_M4,
        S_F_M5,
        S_F_M6,
        S_F_TAIL,
        S_F_T1,
        S_F_T2,
        S_F_T3,
        S_F_T4,
        S_F_T5,
        S_F_T6,
        S_F_W,
        S_F_W1,
        S_F_W2,
        S_F_W3,
        S_F_RET,
        S_R_INIT,
        S_R_SZ,
        S_R_SHR,
        S_R_SHR2,
        S_R_LOOP,
        S_R_L1,
        S_R_L2,
        S_R_G1,
        S_R_G2,
        S_R_G3,
        S_R_AFTER,
        S_R_OK
    } t_state;

endpackage

FILE: rtl/core/bfha_if.sv
// Request and response channel interfaces of the heap allocator.
interface bfha_req_if;
    logic                         valid;
    logic                         ready;
    logic [bfha_pkg::CMD_W-1:0]   command;
    logic [bfha_pkg::ADDR_W-1:0]  block_address;
    logic [bfha_pkg::LEN_W-1:0]   request_length;

    modport source (output valid, command, block_address, request_length, input ready);
    modport sink   (input valid, command, block_address, request_length, output ready);
endinterface

interface bfha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfha_pkg::ADDR_W-1:0]  result_address;
    logic                         status;
    logic                         move_needed;
    logic [bfha_pkg::LEN_W-1:0]   copy_length;
    logic [bfha_pkg::LEN_W-1:0]   clear_length;

    modport source (output valid, result_address, status, move_needed, copy_length,
                    clear_length, input ready);
    modport sink   (input valid, result_address, status, move_needed, copy_length,
                    clear_length, output ready);
endinterface

FILE: rtl/core/best_fit_heap_allocator_top.sv
// Best-fit heap allocator: sequencer, shared header access unit and heap byte memory.
// Every 32-bit header or link access, read or write, goes byte by byte through the
// single-byte memory port; the free list walks of allocate, resize and free and the splice
// are built from such accesses. One command at a time.
// The request channel is ready again once the response word has been taken.
// Reset (synchronous, active low) empties the free list, puts the break at the heap
// start and loads heap_base = 0, heap_end = 16384; heap bytes are not cleared.
module best_fit_heap_allocator_top #(
    parameter int HEAP_BYTES = 16384
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bfha_pkg::CFG_W-1:0]  i_cfg_data,
    bfha_req_if.sink                    i_req,
    bfha_rsp_if.source                  o_rsp
);

    localparam int AW         = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
    localparam int BW         = $clog2(HEAP_BYTES + 1);
    localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;
    localparam int SW         = $clog2(WALK_LIMIT + 1);
    localparam int WW         = bfha_pkg::WORD_W;

    // A list pointer at or beyond the heap size terminates the free list.
    function automatic logic at_end(input bfha_pkg::t_word x);
        at_end = x >= WW'(HEAP_BYTES);
    endfunction

    // Sequencer state and return points of the access unit and relink step.
    bfha_pkg::t_state r_state, n_state;
    bfha_pkg::t_state r_ret, n_ret;
    bfha_pkg::t_state r_rl_ret, n_rl_ret;
    bfha_pkg::t_ctx   r_ctx, n_ctx;

    // Configuration and persistent allocator state.
    logic [bfha_pkg::CFG_W-1:0]  r_base, r_end;
    logic [bfha_pkg::ADDR_W-1:0] r_head, n_head;
    logic [BW-1:0]               r_brk, n_brk;

    // Working registers of the current command.
    logic [bfha_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [bfha_pkg::LEN_W-1:0]  r_len, n_len;
    bfha_pkg::t_word r_alen, n_alen;
    bfha_pkg::t_word r_p, n_p;
    bfha_pkg::t_word r_fp, n_fp;
    bfha_pkg::t_word r_sz, n_sz;
    bfha_pkg::t_word r_prev, n_prev;
    bfha_pkg::t_word r_cur, n_cur;
    bfha_pkg::t_word r_s, n_s;
    bfha_pkg::t_word r_sn, n_sn;
    bfha_pkg::t_word r_sp, n_sp;
    bfha_pkg::t_word r_t, n_t;
    bfha_pkg::t_word r_q, n_q;
    logic                        r_found, n_found;
    logic [SW-1:0]               r_steps, n_steps;
    logic [bfha_pkg::ADDR_W-1:0] r_rlv, n_rlv;

    // Header access unit: one byte per cycle through the memory port.
    bfha_pkg::t_word             r_maddr, n_maddr;
    logic [31:0]                 r_mdata, n_mdata;
    logic [2:0]                  r_mcnt, n_mcnt;
    logic [31:0]                 r_rv, n_rv;
    logic                        r_rd_ok, n_rd_ok;

    // Response word.
    logic [bfha_pkg::ADDR_W-1:0] r_res_addr, n_res_addr;
    logic                        r_status, n_status;
    logic                        r_move, n_move;
    logic [bfha_pkg::LEN_W-1:0]  r_copy, n_copy;
    logic [bfha_pkg::LEN_W-1:0]  r_clear, n_clear;

    // Heap byte memory.
    logic [7:0] r_heap [HEAP_BYTES];
    logic [7:0] r_mem_q;
    bfha_pkg::t_word  w_mem_a;
    logic             w_mem_ok;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_idx;

    // Derived values shared by both sequencer blocks.
    logic            w_accept;
    logic [31:0]     w_in_off;
    logic            w_in_valid;
    bfha_pkg::t_word w_brk, w_len, w_rv, w_e, w_fh, w_h, w_nxt, w_incr;
    logic            w_cur_end, w_prev_end, w_rv_end, w_lim;
    logic            w_a_best, w_a_fail, w_grow, w_shrink_split, w_wrap;
    logic [32:0]     w_end_diff;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_off   = i_req.block_address - r_base;
    assign w_brk      = WW'(r_brk);
    assign w_in_valid = (i_req.block_address != '0) && (w_in_off >= 32'd4) &&
                        (WW'(w_in_off) <= w_brk);
    assign w_len      = WW'(r_len);
    assign w_rv       = WW'(r_rv);
    assign w_fh       = r_fp - bfha_pkg::HDR;
    assign w_h        = r_p - bfha_pkg::HDR;
    assign w_nxt      = r_p + r_sz;
    assign w_incr     = w_len - r_sz;
    assign w_cur_end  = at_end(r_cur);
    assign w_prev_end = at_end(r_prev);
    assign w_rv_end   = at_end(w_rv);
    assign w_lim      = r_steps >= SW'(WALK_LIMIT);
    assign w_wrap     = (33'(r_addr) + 33'(r_len)) > 33'h0_FFFF_FFFF;

    // Usable end offset: heap_end - heap_base clamped to the heap size, zero if not positive.
    assign w_end_diff = 33'(r_end) - 33'(r_base);
    always_comb begin
        if (r_end <= r_base) begin
            w_e = '0;
        end else if (WW'(w_end_diff) > WW'(HEAP_BYTES)) begin
            w_e = WW'(HEAP_BYTES);
        end else begin
            w_e = WW'(w_end_diff);
        end
    end

    // Best-fit candidate: strictly larger than the request and smaller than the best so far.
    assign w_a_best = (r_t > r_alen) && (!r_found || (r_t < r_s));
    assign w_a_fail = (w_e <= w_brk) || ((w_e - w_brk) < (r_alen + bfha_pkg::HDR));
    // The free chunk just above the block can absorb the growth.
    assign w_grow   = (r_cur == w_nxt) && ((w_rv + bfha_pkg::HDR) >= w_incr);
    // A shrink splits only when the cut-off tail can hold a chunk of its own.
    assign w_shrink_split = (w_rv > bfha_pkg::SPLIT) && (w_len <= (w_rv - bfha_pkg::SPLIT));

    // Memory port: the access unit walks four consecutive bytes; bytes beyond the
    // heap read as zero and drop writes.
    assign w_mem_a   = r_maddr + WW'(r_mcnt);
    assign w_mem_ok  = w_mem_a < WW'(HEAP_BYTES);
    assign w_mem_idx = w_mem_a[AW-1:0];
    assign w_mem_we  = (r_state == bfha_pkg::S_WR) && w_mem_ok;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_heap[w_mem_idx] <= r_mdata[7:0];
        end
        r_mem_q <= r_heap[w_mem_idx];
    end

    assign i_req.ready          = (r_state == bfha_pkg::S_IDLE);
    assign o_rsp.valid          = (r_state == bfha_pkg::S_DONE);
    assign o_rsp.result_address = r_res_addr;
    assign o_rsp.status         = r_status;
    assign o_rsp.move_needed    = r_move;
    assign o_rsp.copy_length    = r_copy;
    assign o_rsp.clear_length   = r_clear;

    // Next-state logic. Every header access goes to S_RD or S_WR with the
    // state to resume in held in r_ret.
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_rl_ret = r_rl_ret;
        case (r_state)
            bfha_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_req.command)
                        bfha_pkg::CMD_ALLOC: n_state = bfha_pkg::S_A_INIT;
                        bfha_pkg::CMD_FREE: begin
                            n_state = w_in_valid ? bfha_pkg::S_F_INIT : bfha_pkg::S_DONE;
                        end
                        bfha_pkg::CMD_RESIZE: begin
                            if (i_req.block_address == '0) begin
                                n_state = bfha_pkg::S_A_INIT;
                            end else if (!w_in_valid) begin
                                n_state = bfha_pkg::S_DONE;
                            end else begin
                                n_state = bfha_pkg::S_R_INIT;
                            end
                        end
                        default: n_state = bfha_pkg::S_DONE;
                    endcase
                end
            end
            bfha_pkg::S_RD: begin
                if (r_mcnt == 3'd4) begin
                    n_state = r_ret;
                end
            end
            bfha_pkg::S_WR: begin
                if (r_mcnt == 3'd3) begin
                    n_state = r_ret;
                end
            end
            bfha_pkg::S_REL: begin
                if (w_prev_end) begin
                    n_state = r_rl_ret;
                end else begin
                    n_state = bfha_pkg::S_WR;
                    n_ret   = r_rl_ret;
                end
            end
            bfha_pkg::S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = bfha_pkg::S_IDLE;
                end
            end
            // Allocation.
            bfha_pkg::S_A_INIT: n_state = bfha_pkg::S_A_LOOP;
            bfha_pkg::S_A_LOOP: begin
                if (!w_cur_end && !w_lim) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_A_SZ;
                end else begin
                    n_state = bfha_pkg::S_A_AFTER;
                end
            end
            bfha_pkg::S_A_SZ: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_A_NEXT;
            end
            bfha_pkg::S_A_NEXT: begin
                if (r_t == r_alen) begin
                    n_state  = bfha_pkg::S_REL;
                    n_rl_ret = bfha_pkg::S_A_RET;
                end else begin
                    n_state = bfha_pkg::S_A_LOOP;
                end
            end
            bfha_pkg::S_A_AFTER: begin
                if (r_found) begin
                    if ((r_s - r_alen) < bfha_pkg::SPLIT) begin
                        n_state = bfha_pkg::S_RD;
                        n_ret   = bfha_pkg::S_A_SPL;
                    end else begin
                        n_state = bfha_pkg::S_WR;
                        n_ret   = bfha_pkg::S_A_SPL2;
                    end
                end else if (w_a_fail) begin
                    n_state = bfha_pkg::S_A_RET;
                end else begin
                    n_state = bfha_pkg::S_WR;
                    n_ret   = bfha_pkg::S_A_RET;
                end
            end
            bfha_pkg::S_A_SPL: begin
                n_state  = bfha_pkg::S_REL;
                n_rl_ret = bfha_pkg::S_A_RET;
            end
            bfha_pkg::S_A_SPL2: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_A_RET;
            end
            bfha_pkg::S_A_RET: begin
                if (r_ctx == bfha_pkg::CTX_MOVE && r_q != '0) begin
                    n_state = bfha_pkg::S_F_INIT;
                end else begin
                    n_state = bfha_pkg::S_DONE;
                end
            end
            // Free with coalescing.
            bfha_pkg::S_F_INIT: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_F_CHK;
            end
            bfha_pkg::S_F_CHK: begin
                if (at_end(WW'(r_head))) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_F_EMPTY;
                end else begin
                    n_state = bfha_pkg::S_F_LOOP;
                end
            end
            bfha_pkg::S_F_EMPTY: n_state = bfha_pkg::S_F_RET;
            bfha_pkg::S_F_LOOP: begin
                if (!w_cur_end && !w_lim) begin
                    if (r_cur < w_fh) begin
                        n_state = bfha_pkg::S_RD;
                        n_ret   = bfha_pkg::S_F_ADV;
                    end else begin
                        n_state = bfha_pkg::S_WR;
                        n_ret   = bfha_pkg::S_F_M1;
                    end
                end else begin
                    n_state = bfha_pkg::S_F_TAIL;
                end
            end
            bfha_pkg::S_F_ADV: n_state = bfha_pkg::S_F_LOOP;
            bfha_pkg::S_F_M1: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_F_M2;
            end
            bfha_pkg::S_F_M2: begin
                if ((r_fp + w_rv) == r_cur) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_F_M3;
                end else begin
                    n_state = bfha_pkg::S_F_M6;
                end
            end
            bfha_pkg::S_F_M3: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_F_M4;
            end
            bfha_pkg::S_F_M4: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_F_M5;
            end
            bfha_pkg::S_F_M5: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_F_M6;
            end
            bfha_pkg::S_F_M6: begin
                n_state = w_prev_end ? bfha_pkg::S_F_RET : bfha_pkg::S_F_TAIL;
            end
            bfha_pkg::S_F_TAIL: begin
                if (w_prev_end) begin
                    n_state = bfha_pkg::S_F_RET;
                end else begin
                    n_state = bfha_pkg::S_WR;
                    n_ret   = bfha_pkg::S_F_T1;
                end
            end
            bfha_pkg::S_F_T1: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_F_T2;
            end
            bfha_pkg::S_F_T2: begin
                if ((r_prev + bfha_pkg::HDR + w_rv) == w_fh) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_F_T3;
                end else begin
                    n_state = bfha_pkg::S_F_T6;
                end
            end
            bfha_pkg::S_F_T3: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_F_T4;
            end
            bfha_pkg::S_F_T4: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_F_T5;
            end
            bfha_pkg::S_F_T5: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_F_T6;
            end
            bfha_pkg::S_F_T6: n_state = bfha_pkg::S_F_W;
            bfha_pkg::S_F_W: begin
                if (!w_lim) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_F_W1;
                end else begin
                    n_state = bfha_pkg::S_F_W2;
                end
            end
            bfha_pkg::S_F_W1: n_state = w_rv_end ? bfha_pkg::S_F_W2 : bfha_pkg::S_F_W;
            bfha_pkg::S_F_W2: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = bfha_pkg::S_F_W3;
            end
            bfha_pkg::S_F_W3: begin
                if ((r_cur + bfha_pkg::HDR + w_rv) == w_brk) begin
                    n_state  = bfha_pkg::S_REL;
                    n_rl_ret = bfha_pkg::S_F_RET;
                end else begin
                    n_state = bfha_pkg::S_F_RET;
                end
            end
            bfha_pkg::S_F_RET: n_state = bfha_pkg::S_DONE;
            // Resize.
            bfha_pkg::S_R_INIT: begin
                if (w_wrap) begin
                    n_state = bfha_pkg::S_DONE;
                end else begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_R_SZ;
                end
            end
            bfha_pkg::S_R_SZ: begin
                if (w_len <= w_rv) begin
                    if (w_shrink_split) begin
                        n_state = bfha_pkg::S_WR;
                        n_ret   = bfha_pkg::S_R_SHR;
                    end else begin
                        n_state = bfha_pkg::S_R_OK;
                    end
                end else begin
                    n_state = bfha_pkg::S_R_LOOP;
                end
            end
            bfha_pkg::S_R_SHR: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_R_SHR2;
            end
            bfha_pkg::S_R_SHR2: n_state = bfha_pkg::S_F_INIT;
            bfha_pkg::S_R_LOOP: begin
                if (!w_cur_end && !w_lim) begin
                    n_state = bfha_pkg::S_RD;
                    n_ret   = bfha_pkg::S_R_L1;
                end else begin
                    n_state = bfha_pkg::S_R_AFTER;
                end
            end
            bfha_pkg::S_R_L1: begin
                n_state = bfha_pkg::S_RD;
                n_ret   = w_grow ? bfha_pkg::S_R_G1 : bfha_pkg::S_R_L2;
            end
            bfha_pkg::S_R_L2: n_state = bfha_pkg::S_R_LOOP;
            bfha_pkg::S_R_G1: begin
                n_state  = bfha_pkg::S_WR;
                n_rl_ret = bfha_pkg::S_R_OK;
                if ((r_t + bfha_pkg::HDR - w_incr) > bfha_pkg::SPLIT) begin
                    n_ret = bfha_pkg::S_R_G2;
                end else begin
                    n_ret = bfha_pkg::S_REL;
                end
            end
            bfha_pkg::S_R_G2: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_R_G3;
            end
            bfha_pkg::S_R_G3: begin
                n_state = bfha_pkg::S_WR;
                n_ret   = bfha_pkg::S_REL;
            end
            bfha_pkg::S_R_AFTER: begin
                if (w_brk == w_nxt && w_len > r_s) begin
                    if ((r_p + w_len) < w_e) begin
                        n_state = bfha_pkg::S_WR;
                        n_ret   = bfha_pkg::S_R_OK;
                    end else begin
                        n_state = bfha_pkg::S_DONE;
                    end
                end else begin
                    n_state = bfha_pkg::S_A_INIT;
                end
            end
            bfha_pkg::S_R_OK: n_state = bfha_pkg::S_DONE;
            default: n_state = bfha_pkg::S_IDLE;
        endcase
    end

    // Datapath: working registers, access unit and response word.
    always_comb begin
        n_ctx      = r_ctx;
        n_head     = r_head;
        n_brk      = r_brk;
        n_addr     = r_addr;
        n_len      = r_len;
        n_alen     = r_alen;
        n_p        = r_p;
        n_fp       = r_fp;
        n_sz       = r_sz;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_s        = r_s;
        n_sn       = r_sn;
        n_sp       = r_sp;
        n_t        = r_t;
        n_q        = r_q;
        n_found    = r_found;
        n_steps    = r_steps;
        n_rlv      = r_rlv;
        n_maddr    = r_maddr;
        n_mdata    = r_mdata;
        n_mcnt     = r_mcnt;
        n_rv       = r_rv;
        n_rd_ok    = r_rd_ok;
        n_res_addr = r_res_addr;
        n_status   = r_status;
        n_move     = r_move;
        n_copy     = r_copy;
        n_clear    = r_clear;
        case (r_state)
            bfha_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_addr     = i_req.block_address;
                    n_len      = i_req.request_length;
                    n_alen     = (i_req.request_length < 24'd4) ? bfha_pkg::HDR
                                                               : WW'(i_req.request_length);
                    n_p        = WW'(w_in_off);
                    n_fp       = WW'(w_in_off);
                    n_res_addr = '0;
                    n_status   = 1'b0;
                    n_move     = 1'b0;
                    n_copy     = '0;
                    n_clear    = '0;
                    n_ctx      = bfha_pkg::CTX_ALLOC;
                    case (i_req.command)
                        bfha_pkg::CMD_FREE: n_ctx = bfha_pkg::CTX_FREE;
                        bfha_pkg::CMD_RESIZE: begin
                            if (i_req.block_address != '0 && !w_in_valid) begin
                                n_status = 1'b1;
                            end
                        end
                        default: n_ctx = bfha_pkg::CTX_ALLOC;
                    endcase
                end
            end
            bfha_pkg::S_RD: begin
                n_rd_ok = w_mem_ok;
                if (r_mcnt != 3'd0) begin
                    n_rv = {(r_rd_ok ? r_mem_q : 8'd0), r_rv[31:8]};
                end
                n_mcnt = r_mcnt + 3'd1;
            end
            bfha_pkg::S_WR: begin
                n_mdata = {8'd0, r_mdata[31:8]};
                n_mcnt  = r_mcnt + 3'd1;
            end
            bfha_pkg::S_REL: begin
                if (w_prev_end) begin
                    n_head = r_rlv;
                end else begin
                    n_maddr = r_prev + bfha_pkg::HDR;
                    n_mdata = r_rlv;
                    n_mcnt  = '0;
                end
            end
            bfha_pkg::S_A_INIT: begin
                n_prev  = bfha_pkg::NIL;
                n_cur   = WW'(r_head);
                n_found = 1'b0;
                n_s     = '0;
                n_steps = '0;
            end
            bfha_pkg::S_A_LOOP: begin
                n_maddr = r_cur;
                n_mcnt  = '0;
            end
            bfha_pkg::S_A_SZ: begin
                n_t     = w_rv;
                n_maddr = r_cur + bfha_pkg::HDR;
                n_mcnt  = '0;
            end
            bfha_pkg::S_A_NEXT: begin
                if (r_t == r_alen) begin
                    n_rlv = r_rv;
                    n_q   = r_cur + bfha_pkg::HDR;
                end else begin
                    if (w_a_best) begin
                        n_found = 1'b1;
                        n_s     = r_t;
                        n_sn    = r_cur;
                        n_sp    = r_prev;
                    end
                    n_prev  = r_cur;
                    n_cur   = w_rv;
                    n_steps = r_steps + SW'(1);
                end
            end
            bfha_pkg::S_A_AFTER: begin
                n_mcnt = '0;
                if (r_found) begin
                    if ((r_s - r_alen) < bfha_pkg::SPLIT) begin
                        n_maddr = r_sn + bfha_pkg::HDR;
                    end else begin
                        // Carve the request off the top end of the best chunk.
                        n_maddr = r_sn + (r_s - r_alen);
                        n_mdata = r_alen[31:0];
                        n_q     = r_sn + (r_s - r_alen) + bfha_pkg::HDR;
                    end
                end else if (w_a_fail) begin
                    n_q = '0;
                end else begin
                    n_brk   = BW'(w_brk + r_alen + bfha_pkg::HDR);
                    n_maddr = w_brk;
                    n_mdata = r_alen[31:0];
                    n_q     = w_brk + bfha_pkg::HDR;
                end
            end
            bfha_pkg::S_A_SPL: begin
                n_prev = r_sp;
                n_rlv  = r_rv;
                n_q    = r_sn + bfha_pkg::HDR;
            end
            bfha_pkg::S_A_SPL2: begin
                n_maddr = r_sn;
                n_mdata = 32'(r_s - r_alen - bfha_pkg::HDR);
                n_mcnt  = '0;
            end
            bfha_pkg::S_A_RET: begin
                if (r_q == '0) begin
                    n_status = 1'b1;
                end else if (r_ctx == bfha_pkg::CTX_MOVE) begin
                    n_fp = r_p;
                end else begin
                    n_res_addr = r_base + r_q[31:0];
                    n_clear    = r_len;
                end
            end
            bfha_pkg::S_F_INIT: begin
                n_maddr = w_fh + bfha_pkg::HDR;
                n_mdata = bfha_pkg::NIL[31:0];
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_CHK: begin
                n_maddr = w_fh;
                n_mcnt  = '0;
                n_prev  = bfha_pkg::NIL;
                n_cur   = WW'(r_head);
                n_steps = '0;
            end
            bfha_pkg::S_F_EMPTY: begin
                if ((r_fp + w_rv) == w_brk) begin
                    n_brk = BW'(w_fh);
                end else begin
                    n_head = w_fh[31:0];
                end
            end
            bfha_pkg::S_F_LOOP: begin
                n_mcnt = '0;
                if (r_cur < w_fh) begin
                    n_maddr = r_cur + bfha_pkg::HDR;
                end else begin
                    n_maddr = w_fh + bfha_pkg::HDR;
                    n_mdata = r_cur[31:0];
                end
            end
            bfha_pkg::S_F_ADV: begin
                n_prev  = r_cur;
                n_cur   = w_rv;
                n_steps = r_steps + SW'(1);
            end
            bfha_pkg::S_F_M1: begin
                n_maddr = w_fh;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_M2: begin
                n_t     = w_rv;
                n_maddr = r_cur;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_M3: begin
                n_maddr = w_fh;
                n_mdata = 32'(r_t + w_rv + bfha_pkg::HDR);
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_M4: begin
                n_maddr = r_cur + bfha_pkg::HDR;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_M5: begin
                n_maddr = w_fh + bfha_pkg::HDR;
                n_mdata = r_rv;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_M6: begin
                if (w_prev_end) begin
                    n_head = w_fh[31:0];
                end
            end
            bfha_pkg::S_F_TAIL: begin
                n_maddr = r_prev + bfha_pkg::HDR;
                n_mdata = w_fh[31:0];
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T1: begin
                n_maddr = r_prev;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T2: begin
                n_t     = w_rv;
                n_maddr = w_fh;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T3: begin
                n_maddr = r_prev;
                n_mdata = 32'(r_t + w_rv + bfha_pkg::HDR);
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T4: begin
                n_maddr = w_fh + bfha_pkg::HDR;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T5: begin
                n_maddr = r_prev + bfha_pkg::HDR;
                n_mdata = r_rv;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_T6: begin
                n_prev  = bfha_pkg::NIL;
                n_cur   = WW'(r_head);
                n_steps = '0;
            end
            bfha_pkg::S_F_W: begin
                n_maddr = r_cur + bfha_pkg::HDR;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_W1: begin
                if (!w_rv_end) begin
                    n_prev  = r_cur;
                    n_cur   = w_rv;
                    n_steps = r_steps + SW'(1);
                end
            end
            bfha_pkg::S_F_W2: begin
                n_maddr = r_cur;
                n_mcnt  = '0;
            end
            bfha_pkg::S_F_W3: begin
                // The last free chunk touches the break: hand it back.
                if ((r_cur + bfha_pkg::HDR + w_rv) == w_brk) begin
                    n_brk = BW'(r_cur);
                    n_rlv = bfha_pkg::NIL[31:0];
                end
            end
            bfha_pkg::S_F_RET: begin
                case (r_ctx)
                    bfha_pkg::CTX_SHRINK: n_res_addr = r_addr;
                    bfha_pkg::CTX_MOVE: begin
                        n_res_addr = r_base + r_q[31:0];
                        n_move     = 1'b1;
                        n_copy     = r_sz[bfha_pkg::LEN_W-1:0];
                        n_clear    = r_len;
                    end
                    default: n_res_addr = '0;
                endcase
            end
            bfha_pkg::S_R_INIT: begin
                if (w_wrap) begin
                    n_status = 1'b1;
                end
                n_maddr = w_h;
                n_mcnt  = '0;
            end
            bfha_pkg::S_R_SZ: begin
                n_sz    = w_rv;
                n_maddr = r_p + w_len;
                n_mdata = 32'(w_rv - w_len - bfha_pkg::HDR);
                n_mcnt  = '0;
                n_prev  = bfha_pkg::NIL;
                n_cur   = WW'(r_head);
                n_s     = '0;
                n_steps = '0;
            end
            bfha_pkg::S_R_SHR: begin
                n_maddr = w_h;
                n_mdata = 32'(r_len);
                n_mcnt  = '0;
            end
            bfha_pkg::S_R_SHR2: begin
                n_fp  = r_p + w_len + bfha_pkg::HDR;
                n_ctx = bfha_pkg::CTX_SHRINK;
            end
            bfha_pkg::S_R_LOOP: begin
                n_maddr = r_cur;
                n_mcnt  = '0;
            end
            bfha_pkg::S_R_L1: begin
                n_t     = w_rv;
                n_maddr = r_cur + bfha_pkg::HDR;
                n_mcnt  = '0;
                if (!w_grow && w_rv > r_s) begin
                    n_s = w_rv;
                end
            end
            bfha_pkg::S_R_L2: begin
                n_prev  = r_cur;
                n_cur   = w_rv;
                n_steps = r_steps + SW'(1);
            end
            bfha_pkg::S_R_G1: begin
                n_mcnt = '0;
                if ((r_t + bfha_pkg::HDR - w_incr) > bfha_pkg::SPLIT) begin
                    // The rest of the neighbor stays free above the grown block.
                    n_maddr = r_p + w_len + bfha_pkg::HDR;
                    n_mdata = r_rv;
                    n_rlv   = 32'(r_p + w_len);
                end else begin
                    n_maddr = w_h;
                    n_mdata = 32'(r_sz + r_t + bfha_pkg::HDR);
                    n_rlv   = r_rv;
                end
            end
            bfha_pkg::S_R_G2: begin
                n_maddr = r_p + w_len;
                n_mdata = 32'(r_t - w_incr);
                n_mcnt  = '0;
            end
            bfha_pkg::S_R_G3: begin
                n_maddr = w_h;
                n_mdata = 32'(r_len);
                n_mcnt  = '0;
            end
            bfha_pkg::S_R_AFTER: begin
                if (w_brk == w_nxt && w_len > r_s) begin
                    if ((r_p + w_len) < w_e) begin
                        n_brk   = BW'(r_p + w_len);
                        n_maddr = w_h;
                        n_mdata = 32'(r_len);
                        n_mcnt  = '0;
                    end else begin
                        n_status = 1'b1;
                    end
                end else begin
                    n_ctx = bfha_pkg::CTX_MOVE;
                end
            end
            bfha_pkg::S_R_OK: n_res_addr = r_addr;
            default: n_rd_ok = r_rd_ok;
        endcase
    end

    // Control state, configuration and allocator state: set by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfha_pkg::S_IDLE;
            r_head  <= bfha_pkg::NIL[31:0];
            r_brk   <= '0;
            r_base  <= '0;
            r_end   <= bfha_pkg::HEAP_END_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_brk   <= n_brk;
            if (i_cfg_we) begin
                if (i_cfg_idx == bfha_pkg::CFG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_end <= i_cfg_data;
                end
            end
        end
    end

    // Working registers and response word.
    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_rl_ret   <= n_rl_ret;
        r_ctx      <= n_ctx;
        r_addr     <= n_addr;
        r_len      <= n_len;
        r_alen     <= n_alen;
        r_p        <= n_p;
        r_fp       <= n_fp;
        r_sz       <= n_sz;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_s        <= n_s;
        r_sn       <= n_sn;
        r_sp       <= n_sp;
        r_t        <= n_t;
        r_q        <= n_q;
        r_found    <= n_found;
        r_steps    <= n_steps;
        r_rlv      <= n_rlv;
        r_maddr    <= n_maddr;
        r_mdata    <= n_mdata;
        r_mcnt     <= n_mcnt;
        r_rv       <= n_rv;
        r_rd_ok    <= n_rd_ok;
        r_res_addr <= n_res_addr;
        r_status   <= n_status;
        r_move     <= n_move;
        r_copy     <= n_copy;
        r_clear    <= n_clear;
    end

endmodule

FILE: dv/bfha_checker.sv
// Checker for the heap allocator: mirrors the heap state and scores every response word.
module bfha_checker
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bfha_req_if              i_req,
    bfha_rsp_if              i_rsp,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] t_u64;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              oom;
        logic              moved;
        logic [LEN_W-1:0]  copy_len;
        logic [LEN_W-1:0]  clear_len;
    } t_answer;

    localparam t_u64 LIST_END = 64'hFFFF_FFFF;
    localparam t_u64 M32      = 64'hFFFF_FFFF;
    localparam int   WALK_MAX = HEAP_BYTES / 8 + 2;

    logic [7:0] heap_bytes [HEAP_BYTES];
    t_u64       brk;
    t_u64       head;
    t_u64       base;
    t_u64       hend;
    t_answer    answers_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        foreach (heap_bytes[i]) heap_bytes[i] = 8'h00;
    end

    function automatic t_u64 rd_word(t_u64 off);
        t_u64 v;
        v = 0;
        for (int i = 0; i < 4; i++) begin
            if (off + i < HEAP_BYTES) v |= t_u64'(heap_bytes[off + i]) << (8 * i);
        end
        return v;
    endfunction

    function automatic void wr_word(t_u64 off, t_u64 v);
        for (int i = 0; i < 4; i++) begin
            if (off + i < HEAP_BYTES) heap_bytes[off + i] = 8'(v >> (8 * i));
        end
    endfunction

    function automatic bit is_end(t_u64 x);
        return x >= HEAP_BYTES;
    endfunction

    function automatic t_u64 link(t_u64 n);
        return rd_word(n + 4);
    endfunction

    function automatic void set_link(t_u64 n, t_u64 v);
        wr_word(n + 4, v);
    endfunction

    function automatic t_u64 usable_end();
        t_u64 d;
        if (hend <= base) return 0;
        d = hend - base;
        return (d > HEAP_BYTES) ? t_u64'(HEAP_BYTES) : d;
    endfunction

    function automatic void splice(t_u64 prev, t_u64 v);
        if (is_end(prev)) head = v & M32;
        else set_link(prev, v);
    endfunction

    // Best fit: exact match first, else split the smallest larger chunk, else bump the break.
    function automatic t_u64 carve(t_u64 len);
        t_u64 prev, cur, s, sn, sp, sz, cp, e, c;
        bit   found;
        int   steps;
        prev = LIST_END; cur = head; s = 0; sn = 0; sp = LIST_END;
        found = 0; steps = 0;
        if (len < 4) len = 4;
        while (!is_end(cur) && steps < WALK_MAX) begin
            sz = rd_word(cur);
            if (sz == len) begin
                splice(prev, link(cur));
                return cur + 4;
            end
            if (sz > len && (!found || sz < s)) begin
                found = 1; s = sz; sn = cur; sp = prev;
            end
            prev = cur;
            cur  = link(cur);
            steps++;
        end
        if (found) begin
            if (s - len < 8) begin
                splice(sp, link(sn));
                return sn + 4;
            end
            cp = sn + (s - len);
            wr_word(cp, len);
            wr_word(sn, s - len - 4);
            return cp + 4;
        end
        e = usable_end();
        c = brk;
        if (e <= c || e - c < len + 4) return 0;
        brk = (c + len + 4) & M32;
        wr_word(c, len);
        return c + 4;
    endfunction

    // Return a chunk to the address-ordered list, merging with both neighbors,
    // and give the topmost free chunk back to the break.
    function automatic void release_chunk(t_u64 p);
        t_u64 h, prev, cur;
        int   steps;
        h = p - 4; prev = LIST_END; cur = head; steps = 0;
        set_link(h, LIST_END);
        if (is_end(head)) begin
            if (p + rd_word(h) == brk) brk = h & M32;
            else head = h & M32;
            return;
        end
        while (!is_end(cur) && steps < WALK_MAX) begin
            if (cur < h) begin
                prev = cur;
                cur  = link(cur);
                steps++;
                continue;
            end
            set_link(h, cur);
            if (p + rd_word(h) == cur) begin
                wr_word(h, rd_word(h) + rd_word(cur) + 4);
                set_link(h, link(cur));
            end
            if (is_end(prev)) begin
                head = h & M32;
                return;
            end
            break;
        end
        if (is_end(prev)) return;
        set_link(prev, h);
        if (prev + 4 + rd_word(prev) == h) begin
            wr_word(prev, rd_word(prev) + rd_word(h) + 4);
            set_link(prev, link(h));
        end
        prev = LIST_END; cur = head; steps = 0;
        while (steps < WALK_MAX && !is_end(link(cur))) begin
            prev = cur;
            cur  = link(cur);
            steps++;
        end
        if (cur + 4 + rd_word(cur) == brk) begin
            splice(prev, LIST_END);
            brk = cur & M32;
        end
    endfunction

    function automatic t_answer alloc_answer(t_u64 len);
        t_answer a;
        t_u64    p;
        a = '0;
        p = carve(len);
        if (p == 0) begin
            a.oom = 1'b1;
        end else begin
            a.address   = ADDR_W'(base + p);
            a.clear_len = LEN_W'(len);
        end
        return a;
    endfunction

    function automatic t_answer resize_answer(t_u64 addr, t_u64 p, t_u64 len);
        t_answer a;
        t_u64    h, sz, incr, nxt, prev, cur, s, q, csz, cnx, lk;
        int      steps;
        a = '0;
        h = p - 4; prev = LIST_END; cur = head; s = 0; steps = 0;
        if (addr + len > M32) begin
            a.oom = 1'b1;
            return a;
        end
        sz = rd_word(h);
        if (len <= sz) begin
            if (!(sz <= 8 || len > sz - 8)) begin
                wr_word(p + len, sz - len - 4);
                wr_word(h, len);
                release_chunk(p + len + 4);
            end
            a.address = ADDR_W'(addr);
            return a;
        end
        incr = len - sz;
        nxt  = p + sz;
        while (!is_end(cur) && steps < WALK_MAX) begin
            csz = rd_word(cur);
            if (cur == nxt && csz + 4 >= incr) begin
                cnx = link(cur);
                if (csz + 4 - incr > 8) begin
                    lk = p + len;
                    set_link(lk, cnx);
                    wr_word(lk, csz - incr);
                    wr_word(h, len);
                end else begin
                    wr_word(h, sz + csz + 4);
                    lk = cnx;
                end
                splice(prev, lk);
                a.address = ADDR_W'(addr);
                return a;
            end
            if (csz > s) s = csz;
            prev = cur;
            cur  = link(cur);
            steps++;
        end
        if (brk == p + sz && len > s) begin
            if (p + len < usable_end()) begin
                brk = (p + len) & M32;
                wr_word(h, len);
                a.address = ADDR_W'(addr);
            end else begin
                a.oom = 1'b1;
            end
            return a;
        end
        q = carve(len);
        if (q == 0) begin
            a.oom = 1'b1;
            return a;
        end
        release_chunk(p);
        a.address   = ADDR_W'(base + q);
        a.moved     = 1'b1;
        a.copy_len  = LEN_W'(sz);
        a.clear_len = LEN_W'(len);
        return a;
    endfunction

    function automatic t_answer predict_answer(logic [CMD_W-1:0] cmd, t_u64 addr, t_u64 len);
        t_answer a;
        t_u64    off;
        bit      known;
        a     = '0;
        off   = (addr - base) & M32;
        known = addr != 0 && off >= 4 && off <= brk;
        if (cmd == CMD_ALLOC) begin
            a = alloc_answer(len);
        end else if (cmd == CMD_FREE) begin
            if (known) release_chunk(off);
        end else if (cmd == CMD_RESIZE) begin
            if (addr == 0) a = alloc_answer(len);
            else if (!known) a.oom = 1'b1;
            else a = resize_answer(addr, off, len);
        end
        return a;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            brk  = 0;
            head = LIST_END;
            base = 0;
            hend = t_u64'(HEAP_END_RESET);
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEAP_BASE) base = t_u64'(i_cfg_data);
                else hend = t_u64'(i_cfg_data);
            end
            // The response is scored before a new request is taken in.
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: response word with nothing expected, got address 0x%0h",
                             $time, i_rsp.result_address);
                end else begin
                    want = answers_due.pop_front();
                    check_field("result_address", want.address, i_rsp.result_address);
                    check_field("status", want.oom, i_rsp.status);
                    check_field("move_needed", want.moved, i_rsp.move_needed);
                    check_field("copy_length", want.copy_len, i_rsp.copy_length);
                    check_field("clear_length", want.clear_len, i_rsp.clear_length);
                end
            end
            if (i_req.valid && i_req.ready) begin
                answers_due.push_back(predict_answer(i_req.command,
                                                     t_u64'(i_req.block_address),
                                                     t_u64'(i_req.request_length)));
            end
        end
        o_pending = answers_due.size();
    end

endmodule

FILE: dv/tb_best_fit_heap_allocator_top.sv
// Testbench top of the heap allocator: stimulus, configuration phases and the verdict.
module tb_best_fit_heap_allocator_top;
    import bfha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_BYTES = 16384;
    // Command code that the block must answer with an all-zero word.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        bit               has_old;
        logic [31:0]      old_off;
    } t_sent;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               errors;
    int               pending;

    bfha_req_if req_ch ();
    bfha_rsp_if rsp_ch ();

    // Payload offsets of the blocks currently held, and the commands awaiting a word back.
    logic [31:0] live_offs [$];
    t_sent       sent_q [$];
    logic [31:0] cur_base;
    int          words_sent;
    int          ready_hold;
    bit          src_steady;
    bit          sink_steady;

    best_fit_heap_allocator_top #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    bfha_checker #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The response side: random stalls, an optional steady stretch, and a long
    // hold-off counted down here whenever the stimulus asks for one.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= sink_steady || ($urandom_range(99) >= 26);
        end
    end

    // Follow the response words so that the stimulus knows which blocks are held.
    // A block taken out for free or resize comes back only through its answer.
    always @(posedge clk) begin
        t_sent s;
        if (rst_n && rsp_ch.valid && rsp_ch.ready && sent_q.size() > 0) begin
            s = sent_q.pop_front();
            if ((s.cmd == CMD_ALLOC || s.cmd == CMD_RESIZE) && !rsp_ch.status
                    && rsp_ch.result_address != 0) begin
                live_offs.push_back(rsp_ch.result_address - cur_base);
            end else if (s.has_old && rsp_ch.status) begin
                live_offs.push_back(s.old_off);
            end
        end
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one word, idling first at random unless a steady stretch is on.
    task automatic offer_word(logic [CMD_W-1:0] cmd, logic [31:0] addr, logic [23:0] len,
                              bit has_old = 0, logic [31:0] old_off = 0);
        t_sent s;
        if (!src_steady) begin
            while ($urandom_range(99) < 26) begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.block_address  <= addr;
        req_ch.request_length <= len;
        do @(posedge clk); while (!req_ch.ready);
        s.cmd     = cmd;
        s.has_old = has_old;
        s.old_off = old_off;
        sent_q.push_back(s);
        words_sent++;
    endtask

    task automatic take_live(logic [31:0] off);
        foreach (live_offs[i]) begin
            if (live_offs[i] == off) begin
                live_offs.delete(i);
                break;
            end
        end
    endtask

    task automatic free_block(logic [31:0] off);
        take_live(off);
        offer_word(CMD_FREE, cur_base + off, '0);
    endtask

    task automatic resize_block(logic [31:0] off, logic [23:0] len);
        take_live(off);
        offer_word(CMD_RESIZE, cur_base + off, len, 1'b1, off);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic settle();
        @(posedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0 || sent_q.size() != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic set_window(logic [31:0] base, logic [31:0] heap_end);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEAP_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_idx  <= CFG_HEAP_END;
        cfg_data <= heap_end;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_base = base;
    endtask

    // An address that the block must treat as unknown: nonzero and outside
    // the handed-out part of the heap.
    function automatic logic [31:0] stray_address();
        logic [31:0] a;
        do a = $urandom; while (a == 0 || ((a - cur_base) >= 4 && (a - cur_base) <= HEAP_BYTES));
        return a;
    endfunction

    function automatic logic [23:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 24'($urandom);
        if (r < 8) return 24'($urandom_range(200, 2000));
        return 24'($urandom_range(0, 48));
    endfunction

    // Mostly well-formed traffic on held blocks, with some noise mixed in.
    task automatic random_words(int count);
        int          r;
        logic [31:0] off;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 25 && live_offs.size() > 0) begin
                off = live_offs[$urandom_range(live_offs.size() - 1)];
                free_block(off);
            end else if (r < 45 && live_offs.size() > 0) begin
                off = live_offs[$urandom_range(live_offs.size() - 1)];
                resize_block(off, (r < 28) ? 24'($urandom) : 24'($urandom_range(0, 96)));
            end else if (r < 50) begin
                offer_word(CMD_RESIZE, '0, pick_length());
            end else if (r < 55) begin
                offer_word(($urandom_range(1) != 0) ? CMD_FREE : CMD_RESIZE, stray_address(),
                           24'($urandom));
            end else if (r < 57) begin
                offer_word(CMD_FREE, '0, 24'($urandom));
            end else if (r < 59) begin
                offer_word(CMD_UNUSED, $urandom, 24'($urandom));
            end else begin
                offer_word(CMD_ALLOC, $urandom_range(1) ? $urandom : '0, pick_length());
            end
        end
    endtask

    initial begin
        logic [31:0] a, b, c, d;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_HEAP_BASE;
        cfg_data              = '0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_ALLOC;
        req_ch.block_address  = '0;
        req_ch.request_length = '0;
        cur_base              = '0;
        words_sent            = 0;
        ready_hold            = 0;
        src_steady            = 0;
        sink_steady           = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset window: four blocks, then each kind of
        // reuse, shrink, growth and move on them.
        offer_word(CMD_ALLOC, '0, 24'd16);
        offer_word(CMD_ALLOC, '0, 24'd16);
        offer_word(CMD_ALLOC, '0, 24'd16);
        offer_word(CMD_ALLOC, '0, 24'd32);
        settle();
        a = live_offs[0];
        b = live_offs[1];
        c = live_offs[2];
        d = live_offs[3];
        free_block(b);
        settle();
        // Same size again takes the freed chunk whole.
        offer_word(CMD_ALLOC, '0, 24'd16);
        settle();
        b = live_offs[$];
        // Shrink by too little to split off a chunk: the block stays.
        resize_block(a, 24'd14);
        settle();
        // Shrink with a split, then grow back into the freed tail.
        resize_block(c, 24'd4);
        settle();
        resize_block(c, 24'd12);
        settle();
        // The topmost block grows into the break.
        resize_block(d, 24'd64);
        settle();
        // No room around the first block, so it has to move.
        resize_block(a, 24'd200);
        settle();
        // Requests below four bytes, a huge request, and the corner cases of
        // the address and command fields.
        offer_word(CMD_ALLOC, '0, 24'd0);
        offer_word(CMD_ALLOC, '1, 24'd3);
        offer_word(CMD_ALLOC, '0, 24'hFF_FFFF);
        offer_word(CMD_FREE, '0, 24'hFF_FFFF);
        offer_word(CMD_FREE, 32'd1, '0);
        offer_word(CMD_UNUSED, '1, 24'hFF_FFFF);
        offer_word(CMD_RESIZE, '0, 24'd8);
        offer_word(CMD_RESIZE, '1, 24'd8);
        free_block(b);
        settle();

        // Random traffic at the reset window, with a long response hold-off
        // while words keep being offered so that the input backs up.
        random_words(60);
        ready_hold = 300;
        random_words(40);
        settle();

        // An empty window: heap end at the base, nothing can be handed out.
        set_window('0, '0);
        random_words(20);
        settle();

        // A small window high in the address map.
        set_window(32'h1000_0000, 32'h1000_0800);
        random_words(90);
        settle();

        // The window at the top of the address space, where resizes can
        // wrap the address; no idling on either side here.
        src_steady  = 1;
        sink_steady = 1;
        set_window(32'hFFFF_C000, 32'hFFFF_FFFF);
        random_words(90);
        settle();
        src_steady  = 0;
        sink_steady = 0;

        // Base at its maximum with the end below it.
        set_window('1, '0);
        random_words(15);
        settle();

        // Full width end register, clamped to the heap size.
        set_window('0, '1);
        random_words(80);
        settle();

        $display("Sent %0d request words over six heap windows, including a long output stall.",
                 words_sent);
        $display("Blocks still held at the end: %0d.", live_offs.size());
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
